### rtl/core/jsu_pkg.sv
package jsu_pkg;

  localparam int unsigned RES_MAX = 6;
  localparam int unsigned RES_CNT_W = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [15:0] SURR_HI_LO = 16'hD800;
  localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
  localparam logic [15:0] SURR_LO_LO = 16'hDC00;
  localparam logic [15:0] SURR_LO_HI = 16'hDFFF;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_CLOSED   = 3'd1,
    KIND_BAD_ESC  = 3'd2,
    KIND_BAD_HEX  = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_OPEN_ESC = 3'd5,
    KIND_OPEN_STR = 3'd6
  } kind_t;

  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_HIGH    = 6'b001000,
    MODE_HIGH_BS = 6'b010000,
    MODE_HEX2    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       input_ends;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
  } res_ent_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] hex_accum;
    logic [1:0]  hex_seen;
    logic        hex_bad;
    logic [15:0] held_high;
  } dec_state_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  function automatic utf8_t utf8_encode(logic [20:0] cp_in);
    logic [20:0] cp;
    utf8_t       r;
    cp = cp_in;
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
      cp = CP_REPLACE;
    end
    r = '0;
    if (cp < 21'h000080) begin
      r.b[0] = cp[7:0];
      r.len  = 3'd1;
    end else if (cp < 21'h000800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h010000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

### rtl/core/json_string_unescape_unit.sv
// Streaming JSON string body unescaper: each input item is one byte of a string body, taken
// after the opening quote, or an end-of-input marker, and it yields zero to six result items
// (UTF-8 bytes or status codes, the final one flagged by last). An item is decoded in the
// cycle it is accepted and its results are loaded into a six-entry output queue that drains
// one result item per cycle while out_ready is high. Plain bytes therefore flow at one item
// per cycle while the receiver is ready; an item that expands to n results holds the output
// until its final result leaves, and the next item is taken in the cycle that result leaves.
module json_string_unescape_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jsu_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output jsu_pkg::out_item_t  out_item
);
  import jsu_pkg::*;

  dec_state_t st_r;
  dec_state_t st_nxt;
  res_ent_t   dec_res [RES_MAX];
  logic [2:0] dec_cnt;
  res_ent_t   ent_r [RES_MAX];
  logic [2:0] rem_r;
  logic       in_fire;
  logic       out_fire;

  jsu_decode u_decode (
    .cur     (st_r),
    .item    (in_item),
    .nxt     (st_nxt),
    .res     (dec_res),
    .res_cnt (dec_cnt)
  );

  assign out_valid = (rem_r != 3'd0);
  assign out_fire  = out_valid & out_ready;
  assign in_ready  = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);
  assign in_fire   = in_valid & in_ready;

  assign out_item.out_byte = ent_r[0].value;
  assign out_item.kind     = ent_r[0].kind;
  assign out_item.last     = (rem_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{mode: MODE_PLAIN, default: '0};
      rem_r <= '0;
    end else if (in_fire) begin
      st_r  <= st_nxt;
      rem_r <= dec_cnt;
    end else if (out_fire) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ent_r <= dec_res;
    end else if (out_fire) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        ent_r[i] <= ent_r[i + 1];
      end
    end
  end

endmodule

### rtl/core/jsu_decode.sv
module jsu_decode (
  input  jsu_pkg::dec_state_t cur,
  input  jsu_pkg::in_item_t   item,
  output jsu_pkg::dec_state_t nxt,
  output jsu_pkg::res_ent_t   res [jsu_pkg::RES_MAX],
  output logic [2:0]          res_cnt
);
  import jsu_pkg::*;

  logic        pre;
  logic        use_cp;
  logic [20:0] cp;
  logic        raw_en;
  logic [7:0]  raw_byte;
  kind_t       raw_kind;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic [4:0]  hd;
  logic [15:0] acc_n;
  logic        bad_n;
  logic [15:0] val;
  logic        val_high;
  logic        val_low;
  utf8_t       enc;
  res_ent_t    main [4];
  logic [2:0]  main_n;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = b;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = b;
      CH_B: esc_val = 8'h08;
      CH_F: esc_val = 8'h0C;
      CH_N: esc_val = 8'h0A;
      CH_R: esc_val = 8'h0D;
      CH_T: esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign hd       = hex_value(b);
  assign bad_n    = cur.hex_bad | ~hd[4];
  assign acc_n    = hd[4] ? {cur.hex_accum[11:0], hd[3:0]} : cur.hex_accum;
  assign val      = acc_n;
  assign val_high = (val >= SURR_HI_LO) && (val <= SURR_HI_HI);
  assign val_low  = (val >= SURR_LO_LO) && (val <= SURR_LO_HI);

  always_comb begin
    nxt      = cur;
    pre      = 1'b0;
    use_cp   = 1'b0;
    cp       = '0;
    raw_en   = 1'b0;
    raw_byte = '0;
    raw_kind = KIND_BYTE;
    if (item.input_ends) begin
      raw_en = 1'b1;
      unique case (cur.mode)
        MODE_ESC: raw_kind = KIND_OPEN_ESC;
        MODE_HEX1, MODE_HEX2: raw_kind = KIND_TRUNC;
        MODE_HIGH: begin
          pre      = 1'b1;
          raw_kind = KIND_OPEN_STR;
        end
        MODE_HIGH_BS: begin
          pre      = 1'b1;
          raw_kind = KIND_OPEN_ESC;
        end
        default: raw_kind = KIND_OPEN_STR;
      endcase
      nxt = '{mode: MODE_PLAIN, default: '0};
    end else begin
      unique case (cur.mode)
        MODE_ESC, MODE_HIGH_BS: begin
          if (cur.mode == MODE_HIGH_BS && b == CH_U) begin
            nxt.mode      = MODE_HEX2;
            nxt.hex_accum = '0;
            nxt.hex_seen  = '0;
            nxt.hex_bad   = 1'b0;
          end else if (cur.mode == MODE_ESC && b == CH_U) begin
            nxt.mode      = MODE_HEX1;
            nxt.hex_accum = '0;
            nxt.hex_seen  = '0;
            nxt.hex_bad   = 1'b0;
          end else begin
            pre           = (cur.mode == MODE_HIGH_BS);
            nxt.held_high = '0;
            raw_en        = 1'b1;
            if (esc_ok) begin
              raw_byte = esc_val;
              nxt.mode = MODE_PLAIN;
            end else begin
              raw_kind = KIND_BAD_ESC;
              nxt      = '{mode: MODE_PLAIN, default: '0};
            end
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (cur.hex_seen != 2'd3) begin
            nxt.hex_seen  = cur.hex_seen + 2'd1;
            nxt.hex_accum = acc_n;
            nxt.hex_bad   = bad_n;
          end else if (bad_n) begin
            raw_en   = 1'b1;
            raw_kind = KIND_BAD_HEX;
            nxt      = '{mode: MODE_PLAIN, default: '0};
          end else if (cur.mode == MODE_HEX2 && val_low) begin
            use_cp = 1'b1;
            cp     = {1'b0, cur.held_high[9:0], val[9:0]} + 21'h010000;
            nxt    = '{mode: MODE_PLAIN, default: '0};
          end else begin
            pre = (cur.mode == MODE_HEX2);
            if (val_high) begin
              nxt           = '{mode: MODE_HIGH, default: '0};
              nxt.held_high = val;
            end else begin
              use_cp = 1'b1;
              cp     = {5'd0, val};
              nxt    = '{mode: MODE_PLAIN, default: '0};
            end
          end
        end
        default: begin
          if (cur.mode == MODE_HIGH && b == CH_BSLASH) begin
            nxt.mode = MODE_HIGH_BS;
          end else begin
            pre = (cur.mode == MODE_HIGH);
            if (cur.mode != MODE_PLAIN) begin
              nxt = '{mode: MODE_PLAIN, default: '0};
            end
            if (b == CH_QUOTE) begin
              raw_en   = 1'b1;
              raw_kind = KIND_CLOSED;
              nxt      = '{mode: MODE_PLAIN, default: '0};
            end else if (b == CH_BSLASH) begin
              nxt.mode = MODE_ESC;
            end else begin
              raw_en   = 1'b1;
              raw_byte = b;
            end
          end
        end
      endcase
    end
  end

  assign enc = utf8_encode(cp);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      main[i] = '{value: enc.b[i], kind: KIND_BYTE};
    end
    main_n = '0;
    if (use_cp) begin
      main_n = enc.len;
    end else if (raw_en) begin
      main[0] = '{value: raw_byte, kind: raw_kind};
      main_n  = 3'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '{value: 8'h00, kind: KIND_BYTE};
    end
    if (pre) begin
      res[0].value = 8'hEF;
      res[1].value = 8'hBF;
      res[2].value = 8'hBD;
      res[3]       = main[0];
      res[4]       = main[1];
      res[5]       = main[2];
      res_cnt      = main_n + 3'd3;
    end else begin
      res[0]  = main[0];
      res[1]  = main[1];
      res[2]  = main[2];
      res[3]  = main[3];
      res_cnt = main_n;
    end
  end

endmodule

### verif/json_string_unescape_checker.sv
`timescale 1ns / 1ps

module json_string_unescape_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  jsu_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  jsu_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 outstanding
);
  import jsu_pkg::*;

  out_item_t   decoded_q[$];
  mode_t       dec_mode;
  logic [15:0] hex_acc;
  logic [2:0]  hex_cnt;
  logic        hex_err;
  logic [15:0] pending_high;
  int          step_cnt;

  function automatic void push_result(logic [7:0] b, kind_t k);
    out_item_t r;
    r.out_byte = b;
    r.kind     = k;
    r.last     = 1'b0;
    if (step_cnt < RES_MAX) begin
      decoded_q.insert(decoded_q.size(), r);
      step_cnt++;
    end
  endfunction

  function automatic void push_codepoint(logic [20:0] cp);
    logic [20:0] c;
    c = (cp >= SURR_HI_LO && cp <= SURR_LO_HI) ? CP_REPLACE : cp;
    if (c < 21'h80) begin
      push_result(c[7:0], KIND_BYTE);
    end else if (c < 21'h800) begin
      push_result(8'hC0 | 8'(c >> 6), KIND_BYTE);
      push_result(8'h80 | {2'b00, c[5:0]}, KIND_BYTE);
    end else if (c < 21'h10000) begin
      push_result(8'hE0 | 8'(c >> 12), KIND_BYTE);
      push_result(8'h80 | {2'b00, c[11:6]}, KIND_BYTE);
      push_result(8'h80 | {2'b00, c[5:0]}, KIND_BYTE);
    end else begin
      push_result(8'hF0 | {5'b00000, c[20:18]}, KIND_BYTE);
      push_result(8'h80 | {2'b00, c[17:12]}, KIND_BYTE);
      push_result(8'h80 | {2'b00, c[11:6]}, KIND_BYTE);
      push_result(8'h80 | {2'b00, c[5:0]}, KIND_BYTE);
    end
  endfunction

  function automatic void return_idle();
    dec_mode     = MODE_PLAIN;
    hex_acc      = '0;
    hex_cnt      = '0;
    hex_err      = 1'b0;
    pending_high = '0;
  endfunction

  function automatic void begin_hex(mode_t m);
    dec_mode = m;
    hex_acc  = '0;
    hex_cnt  = '0;
    hex_err  = 1'b0;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    if (b == CH_QUOTE) begin
      push_result(8'h00, KIND_CLOSED);
      return_idle();
    end else if (b == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      push_result(b, KIND_BYTE);
    end
  endfunction

  function automatic void escape_char(logic [7:0] b);
    logic [7:0] v;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: v = b;
      CH_B: v = 8'h08;
      CH_F: v = 8'h0C;
      CH_N: v = 8'h0A;
      CH_R: v = 8'h0D;
      CH_T: v = 8'h09;
      CH_U: begin
        begin_hex(MODE_HEX1);
        return;
      end
      default: begin
        push_result(8'h00, KIND_BAD_ESC);
        return_idle();
        return;
      end
    endcase
    push_result(v, KIND_BYTE);
    dec_mode = MODE_PLAIN;
  endfunction

  // A value standing on its own: a high surrogate is held for a possible pair.
  function automatic void lone_value(logic [15:0] v);
    if (v >= SURR_HI_LO && v <= SURR_HI_HI) begin
      pending_high = v;
      begin_hex(MODE_HIGH);
    end else begin
      push_codepoint({5'b00000, v});
      return_idle();
    end
  endfunction

  function automatic void hex_char(logic [7:0] b);
    logic [3:0]  nib;
    logic        ok;
    logic [15:0] v;
    ok  = 1'b1;
    nib = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      nib = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      nib = 4'(b - 8'h41 + 8'd10);
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      hex_err = 1'b1;
    end else begin
      hex_acc = {hex_acc[11:0], nib};
    end
    hex_cnt++;
    if (hex_cnt < 3'd4) begin
      return;
    end
    if (hex_err) begin
      push_result(8'h00, KIND_BAD_HEX);
      return_idle();
      return;
    end
    v = hex_acc;
    if (dec_mode == MODE_HEX1) begin
      lone_value(v);
    end else if (v >= SURR_LO_LO && v <= SURR_LO_HI) begin
      push_codepoint(21'h10000 + {1'b0, pending_high[9:0], v[9:0]});
      return_idle();
    end else begin
      push_codepoint(CP_REPLACE);
      lone_value(v);
    end
  endfunction

  function automatic void decode_item(in_item_t it);
    step_cnt = 0;
    if (it.input_ends) begin
      case (dec_mode)
        MODE_ESC: push_result(8'h00, KIND_OPEN_ESC);
        MODE_HEX1, MODE_HEX2: push_result(8'h00, KIND_TRUNC);
        MODE_HIGH: begin
          push_codepoint(CP_REPLACE);
          push_result(8'h00, KIND_OPEN_STR);
        end
        MODE_HIGH_BS: begin
          push_codepoint(CP_REPLACE);
          push_result(8'h00, KIND_OPEN_ESC);
        end
        default: push_result(8'h00, KIND_OPEN_STR);
      endcase
      return_idle();
    end else begin
      case (dec_mode)
        MODE_ESC: escape_char(it.data_byte);
        MODE_HEX1, MODE_HEX2: hex_char(it.data_byte);
        MODE_HIGH: begin
          if (it.data_byte == CH_BSLASH) begin
            dec_mode = MODE_HIGH_BS;
          end else begin
            push_codepoint(CP_REPLACE);
            pending_high = '0;
            dec_mode = MODE_PLAIN;
            body_byte(it.data_byte);
          end
        end
        MODE_HIGH_BS: begin
          if (it.data_byte == CH_U) begin
            begin_hex(MODE_HEX2);
          end else begin
            push_codepoint(CP_REPLACE);
            pending_high = '0;
            escape_char(it.data_byte);
          end
        end
        default: body_byte(it.data_byte);
      endcase
    end
    if (step_cnt > 0) begin
      decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      return_idle();
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_item(in_item);
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          note_failure($sformatf("unexpected result item: byte %02h kind %0d last %0d",
                                 out_item.out_byte, out_item.kind, out_item.last));
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.kind !== want.kind ||
              out_item.last !== want.last) begin
            note_failure($sformatf({"result mismatch: expected byte %02h kind %0d last %0d,",
                                    " got byte %02h kind %0d last %0d"},
                                   want.out_byte, want.kind, want.last,
                                   out_item.out_byte, out_item.kind, out_item.last));
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

### verif/tb_json_string_unescape_unit.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_unit;
  import jsu_pkg::*;

  localparam int ITEMS_TOTAL = 130;
  localparam int TAIL_ITEMS  = 30;
  localparam int HOLD_CYCLES = 150;
  localparam int BURST_ITEMS = 20;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {
    SC_PLAIN, SC_SIMPLE_ESC, SC_HEX_VALID, SC_PAIR, SC_BAD_ESC, SC_LONE_LOW,
    SC_HIGH_PLAIN, SC_HIGH_BS_NOT_U, SC_HIGH_NONLOW, SC_BAD_HEX, SC_TRUNC,
    SC_OPEN_ESC, SC_OPEN_STR, SC_NOISE, SC_COUNT
  } scen_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        items_sent;
  int        hold_req;
  int        holds_done;
  int        cycle_count = 0;
  logic      quiet_tail;
  logic      steady;

  json_string_unescape_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  json_string_unescape_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls in random bursts, and holds off for a long stretch on request.
  initial begin : receiver
    int stretch;
    out_ready  = 1'b0;
    holds_done = 0;
    stretch    = 0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done = holds_done + 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        stretch = 0;
      end else if (stretch > 0) begin
        stretch--;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stretch = $urandom_range(1, 19) - 1;
      end else begin
        out_ready <= 1'b1;
        stretch = quiet_tail ? 0 : $urandom_range(0, 23);
      end
    end
  end

  function automatic logic is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_escape(logic [7:0] b);
    return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
           b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U;
  endfunction

  function automatic logic [7:0] hex_ascii(logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_hex(b));
    return b;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] bad_escape();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_escape(b));
    return b;
  endfunction

  function automatic logic [15:0] plain_codepoint();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] high_surr();
    return 16'($urandom_range(SURR_HI_LO, SURR_HI_HI));
  endfunction

  function automatic logic [15:0] low_surr();
    return 16'($urandom_range(SURR_LO_LO, SURR_LO_HI));
  endfunction

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_item(logic [7:0] b, logic ends);
    if (!steady && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_item  <= '{data_byte: b, input_ends: ends};
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_esc(logic [7:0] c);
    send_byte(CH_BSLASH);
    send_byte(c);
  endtask

  task automatic send_uesc(logic [15:0] v);
    send_esc(CH_U);
    for (int i = 3; i >= 0; i--) begin
      send_byte(hex_ascii(v[4*i +: 4]));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_scenario(scen_t s);
    int n;
    case (s)
      SC_PLAIN: begin
        repeat ($urandom_range(1, 6)) send_byte(plain_byte());
        if ($urandom_range(0, 2) == 0) begin
          send_byte(CH_QUOTE);
        end
      end
      SC_SIMPLE_ESC: send_esc(pick_escape());
      SC_HEX_VALID: send_uesc(plain_codepoint());
      SC_PAIR: begin
        send_uesc(high_surr());
        send_uesc(low_surr());
      end
      SC_BAD_ESC: send_esc(bad_escape());
      SC_LONE_LOW: send_uesc(low_surr());
      SC_HIGH_PLAIN: begin
        send_uesc(high_surr());
        send_byte($urandom_range(0, 1) ? CH_QUOTE : plain_byte());
      end
      SC_HIGH_BS_NOT_U: begin
        send_uesc(high_surr());
        send_esc($urandom_range(0, 1) ? pick_escape() : bad_escape());
      end
      SC_HIGH_NONLOW: begin
        send_uesc(high_surr());
        if ($urandom_range(0, 2) == 0) begin
          send_uesc(high_surr());
          if ($urandom_range(0, 1) == 1) begin
            send_uesc(low_surr());
          end
        end else begin
          send_uesc(plain_codepoint());
        end
      end
      SC_BAD_HEX: begin
        if ($urandom_range(0, 1) == 1) begin
          send_uesc(high_surr());
        end
        send_esc(CH_U);
        n = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          if (i == n || $urandom_range(0, 3) == 0) begin
            send_byte(non_hex());
          end else begin
            send_byte(hex_ascii(4'($urandom_range(0, 15))));
          end
        end
      end
      SC_TRUNC: begin
        if ($urandom_range(0, 1) == 1) begin
          send_uesc(high_surr());
        end
        send_esc(CH_U);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 2) == 0) begin
            send_byte(non_hex());
          end else begin
            send_byte(hex_ascii(4'($urandom_range(0, 15))));
          end
        end
        send_end();
      end
      SC_OPEN_ESC: begin
        if ($urandom_range(0, 1) == 1) begin
          send_uesc(high_surr());
        end
        send_byte(CH_BSLASH);
        send_end();
      end
      SC_OPEN_STR: begin
        if ($urandom_range(0, 1) == 1) begin
          send_uesc(high_surr());
        end else begin
          repeat ($urandom_range(0, 3)) send_byte(plain_byte());
        end
        send_end();
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int scen;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    items_sent  = 0;
    hold_req    = 0;
    quiet_tail  = 1'b0;
    steady      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_esc(8'h71);
    send_uesc(16'hD83D);
    send_uesc(16'hDE00);
    send_end();
    send_byte(CH_BSLASH);
    send_end();
    send_esc(CH_U);
    send_byte(8'h31);
    send_end();

    // The receiver holds off while items keep coming, so the block must stall its input.
    steady   = 1'b1;
    hold_req = hold_req + 1;
    repeat (BURST_ITEMS) send_byte(plain_byte());
    steady = 1'b0;
    wait_drained();
    @(negedge clk);

    scen = 0;
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent >= ITEMS_TOTAL - TAIL_ITEMS) begin
        quiet_tail = 1'b1;
      end
      if (scen < SC_COUNT) begin
        run_scenario(scen_t'(scen));
      end else if ($urandom_range(0, 19) < 13) begin
        run_scenario(scen_t'($urandom_range(SC_PLAIN, SC_PAIR)));
      end else begin
        run_scenario(scen_t'($urandom_range(0, SC_COUNT - 1)));
      end
      scen++;
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
